### rtl/fud_pkg.sv
// Shared types and constants for the form-urlencoded decoder.
// No dependencies; imported by every module of the block.
package fud_pkg;

   localparam int MAX_RESULTS  = 5;
   localparam int RESULT_COUNT_WIDTH = 3;

   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_AMP     = 8'h26;
   localparam logic [7:0] CHAR_EQUALS  = 8'h3D;
   localparam logic [7:0] CHAR_LBRACE  = 8'h7B;
   localparam logic [7:0] CHAR_LANGLE  = 8'h3C;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;

   typedef enum logic [2:0] {
      EV_NAME_BYTE  = 3'd0,
      EV_NAME_END   = 3'd1,
      EV_VALUE_BYTE = 3'd2,
      EV_PAIR_DONE  = 3'd3,
      EV_ABANDONED  = 3'd4
   } ev_kind_type;

   typedef struct packed {
      logic [7:0] body_byte;
      logic       end_of_body;
   } req_type;

   typedef struct packed {
      ev_kind_type event_kind;
      logic [7:0]  data_byte;
      logic [5:0]  pair_number;
      logic        last_of_run;
   } rsp_type;

   // Events produced by one item, in order, plus how many are valid.
   typedef struct packed {
      rsp_type [MAX_RESULTS-1:0]      ev;
      logic [RESULT_COUNT_WIDTH-1:0]  count;
   } batch_type;

endpackage

### rtl/fud_parser.sv
// Parser state and per-item event generation for the form-urlencoded decoder.
// Depends on fud_pkg.
module fud_parser #(
   parameter int MAX_PAIRS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  fud_pkg::req_type   req,
   output fud_pkg::batch_type batch
);
   import fud_pkg::*;

   localparam int CW = $clog2(MAX_PAIRS + 1);

   typedef enum logic [5:0] {
      PH_START = 6'b000001,
      PH_NAME  = 6'b000010,
      PH_VALUE = 6'b000100,
      PH_PCT1  = 6'b001000,
      PH_PCT2  = 6'b010000,
      PH_SKIP  = 6'b100000
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [7:0]        held_ff, held_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              nonempty_ff, nonempty_in;

   function automatic logic is_hex(input logic [7:0] b);
      return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
             (b >= 8'h41 && b <= 8'h46);
   endfunction

   function automatic logic [3:0] hex_val(input logic [7:0] b);
      logic [7:0] v;
      if (b >= 8'h30 && b <= 8'h39) v = b - 8'h30;
      else if (b >= 8'h61 && b <= 8'h66) v = b - 8'h57;
      else v = b - 8'h37;
      return v[3:0];
   endfunction

   function automatic rsp_type mk_ev(input ev_kind_type k, input logic [7:0] d,
                                     input logic [5:0] pn);
      rsp_type r;
      r.event_kind  = k;
      r.data_byte   = d;
      r.pair_number = pn;
      r.last_of_run = 1'b0;
      return r;
   endfunction

   always_comb begin
      phase_type                     ph;
      logic [7:0]                    b;
      logic [5:0]                    pn;
      logic                          do_vb;
      logic [CW-1:0]                 cnt_next;
      logic [RESULT_COUNT_WIDTH-1:0] n;
      rsp_type [MAX_RESULTS-1:0]     ev;

      b        = req.body_byte;
      pn       = 6'(cnt_ff);
      cnt_next = cnt_ff + CW'(1);
      do_vb    = 1'b0;
      n        = '0;
      ev       = '0;
      phase_in    = phase_ff;
      held_in     = held_ff;
      cnt_in      = cnt_ff;
      nonempty_in = nonempty_ff;

      ph = phase_ff;
      if (ph == PH_START) begin
         ph = (b == CHAR_LBRACE || b == CHAR_LANGLE) ? PH_SKIP : PH_NAME;
      end
      phase_in = ph;

      unique case (ph)
         PH_NAME: begin
            if (b == CHAR_EQUALS) begin
               ev[n] = mk_ev(EV_NAME_END, 8'h00, pn);
               n = n + 3'd1;
               phase_in = PH_VALUE;
            end else begin
               ev[n] = mk_ev(EV_NAME_BYTE, b, pn);
               n = n + 3'd1;
               nonempty_in = 1'b1;
            end
         end
         PH_VALUE: do_vb = 1'b1;
         PH_PCT1: begin
            if (is_hex(b)) begin
               held_in  = b;
               phase_in = PH_PCT2;
            end else begin
               ev[n] = mk_ev(EV_VALUE_BYTE, CHAR_PERCENT, pn);
               n = n + 3'd1;
               phase_in = PH_VALUE;
               do_vb = 1'b1;
            end
         end
         PH_PCT2: begin
            phase_in = PH_VALUE;
            if (is_hex(b)) begin
               ev[n] = mk_ev(EV_VALUE_BYTE, {hex_val(held_ff), hex_val(b)}, pn);
               n = n + 3'd1;
            end else begin
               ev[n] = mk_ev(EV_VALUE_BYTE, CHAR_PERCENT, pn);
               n = n + 3'd1;
               ev[n] = mk_ev(EV_VALUE_BYTE, held_ff, pn);
               n = n + 3'd1;
               do_vb = 1'b1;
            end
            held_in = 8'h00;
         end
         default: ;
      endcase

      // plain value byte handling, shared by the escape fallbacks
      if (do_vb) begin
         if (b == CHAR_AMP) begin
            ev[n] = mk_ev(EV_PAIR_DONE, 8'h00, pn);
            n = n + 3'd1;
            cnt_in      = cnt_next;
            nonempty_in = 1'b0;
            phase_in    = (cnt_next >= CW'(MAX_PAIRS)) ? PH_SKIP : PH_NAME;
         end else if (b == CHAR_PLUS) begin
            ev[n] = mk_ev(EV_VALUE_BYTE, CHAR_SPACE, pn);
            n = n + 3'd1;
         end else if (b == CHAR_PERCENT) begin
            phase_in = PH_PCT1;
         end else begin
            ev[n] = mk_ev(EV_VALUE_BYTE, b, pn);
            n = n + 3'd1;
         end
      end

      // end of body: flush what is held, then back to reset state
      if (req.end_of_body) begin
         unique case (phase_in)
            PH_NAME: begin
               if (nonempty_in) begin
                  ev[n] = mk_ev(EV_ABANDONED, 8'h00, pn);
                  n = n + 3'd1;
               end
            end
            PH_VALUE: begin
               ev[n] = mk_ev(EV_PAIR_DONE, 8'h00, pn);
               n = n + 3'd1;
            end
            PH_PCT1: begin
               ev[n] = mk_ev(EV_VALUE_BYTE, CHAR_PERCENT, pn);
               n = n + 3'd1;
               ev[n] = mk_ev(EV_PAIR_DONE, 8'h00, pn);
               n = n + 3'd1;
            end
            PH_PCT2: begin
               ev[n] = mk_ev(EV_VALUE_BYTE, CHAR_PERCENT, pn);
               n = n + 3'd1;
               ev[n] = mk_ev(EV_VALUE_BYTE, held_in, pn);
               n = n + 3'd1;
               ev[n] = mk_ev(EV_PAIR_DONE, 8'h00, pn);
               n = n + 3'd1;
            end
            default: ;
         endcase
         phase_in    = PH_START;
         held_in     = 8'h00;
         cnt_in      = '0;
         nonempty_in = 1'b0;
      end

      for (int i = 0; i < MAX_RESULTS; i++) begin
         ev[i].last_of_run = (RESULT_COUNT_WIDTH'(i) + 3'd1 == n);
      end

      batch.ev    = ev;
      batch.count = accept ? n : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_START;
         held_ff     <= 8'h00;
         cnt_ff      <= '0;
         nonempty_ff <= 1'b0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         held_ff     <= held_in;
         cnt_ff      <= cnt_in;
         nonempty_ff <= nonempty_in;
      end
   end

endmodule

### rtl/fud_event_queue.sv
// Result queue: takes a batch of up to five items per cycle, hands out one per cycle unless stalled.
// Depends on fud_pkg.
module fud_event_queue (
   input  logic               clock,
   input  logic               reset,
   input  fud_pkg::batch_type push,
   output logic               room,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output fud_pkg::rsp_type   rsp_data
);
   import fud_pkg::*;

   localparam int DEPTH = 8;
   localparam int AW    = $clog2(DEPTH);
   localparam int CNTW  = $clog2(DEPTH + 1);

   rsp_type           mem [DEPTH];
   logic [AW-1:0]     wr_ff, rd_ff;
   logic [CNTW-1:0]   count_ff;
   logic              pop;

   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_data  = mem[rd_ff];
   // a whole worst-case batch must fit
   assign room      = (count_ff <= CNTW'(DEPTH - MAX_RESULTS));

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
         if (RESULT_COUNT_WIDTH'(i) < push.count) begin
            mem[wr_ff + AW'(i)] <= push.ev[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_ff + AW'(push.count);
         rd_ff    <= rd_ff + AW'(pop);
         count_ff <= count_ff + CNTW'(push.count) - CNTW'(pop);
      end
   end

endmodule

### rtl/form_urlencoded_decoder_unit.sv
// Form-urlencoded body decoder: one body byte per item in, event items out.
// An accepted byte's events are written into the result queue, behind any queued events.
// Throughput: 1 byte per cycle while each byte raises at most one event and the
// result side takes one per cycle; input stalls while more than 3 events wait.
// Reset (synchronous, active high): parser to start of body, result queue emptied.
// Depends on fud_pkg, fud_parser, fud_event_queue.
module form_urlencoded_decoder_unit #(
   parameter int MAX_PAIRS = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  fud_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output fud_pkg::rsp_type rsp_data
);
   import fud_pkg::*;

   batch_type batch;
   logic      room;
   logic      accept;

   // Stall on the queue count alone: the queue must hold a full worst-case
   // batch of five events before a byte is taken.
   assign req_stall = !room;
   assign accept    = req_valid && !req_stall;

   // Parser: phase, held hex digit, pair counter and name flag live here;
   // events for the accepted byte are built in the same cycle.
   fud_parser #(
      .MAX_PAIRS (MAX_PAIRS)
   ) u_parser (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .batch  (batch)
   );

   // Result queue parts the two sides; its head is the output register.
   fud_event_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (batch),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

### rtl/fud_checker.sv
// Port-level checks for the form-urlencoded decoder, bound to the top level.
// Depends on fud_pkg and form_urlencoded_decoder_unit.
module fud_port_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input fud_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input fud_pkg::rsp_type rsp_data
);
   import fud_pkg::*;

   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   a_rsp_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("rsp_data changed while stalled");

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered right after reset");

   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty result queue");

   a_zero_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.event_kind == EV_NAME_END ||
                    rsp_data.event_kind == EV_PAIR_DONE ||
                    rsp_data.event_kind == EV_ABANDONED)
      |-> rsp_data.data_byte == 8'h00)
      else $error("nonzero data_byte on a marker event");

endmodule

bind form_urlencoded_decoder_unit fud_port_checker u_fud_checker (.*);

### tb/sv/fud_checker.sv
// Scoreboard for the form-urlencoded decoder: watches both channels, predicts
// the event items of every accepted body byte and compares them in order.
// Depends on fud_pkg.
`timescale 1ns / 100ps

module fud_checker #(
   parameter int MAX_PAIRS = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  fud_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  fud_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending,
   output int               events_seen
);
   import fud_pkg::*;

   typedef enum logic [5:0] {
      PH_START = 6'b000001,
      PH_NAME  = 6'b000010,
      PH_VALUE = 6'b000100,
      PH_PCT1  = 6'b001000,
      PH_PCT2  = 6'b010000,
      PH_SKIP  = 6'b100000
   } parse_phase_type;

   parse_phase_type phase;
   logic [7:0]      held_digit;
   int unsigned     pairs_done;
   logic            name_started;
   rsp_type         item_events[$];
   rsp_type         expected_events[$];

   task automatic report_mismatch(input string msg);
      fail_count++;
      $display("%0t ns: mismatch: %s", $time, msg);
   endtask

   function automatic void reset_parser();
      phase        = PH_START;
      held_digit   = 8'h00;
      pairs_done   = 0;
      name_started = 1'b0;
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   function automatic logic [3:0] nibble(input logic [7:0] c);
      logic [7:0] v;
      if (c >= "0" && c <= "9") v = c - "0";
      else if (c >= "a" && c <= "f") v = c - "a" + 8'd10;
      else v = c - "A" + 8'd10;
      return v[3:0];
   endfunction

   // At most MAX_RESULTS events per item; extras are dropped.
   function automatic void add_event(input ev_kind_type kind, input logic [7:0] data);
      rsp_type ev;
      if (item_events.size() >= MAX_RESULTS) return;
      ev.event_kind  = kind;
      ev.data_byte   = data;
      ev.pair_number = pairs_done[5:0];
      ev.last_of_run = 1'b0;
      item_events.push_back(ev);
   endfunction

   function automatic void close_pair();
      add_event(EV_PAIR_DONE, 8'h00);
      pairs_done++;
      name_started = 1'b0;
      phase = (pairs_done >= MAX_PAIRS) ? PH_SKIP : PH_NAME;
   endfunction

   function automatic void value_phase_byte(input logic [7:0] b);
      if (b == CHAR_AMP) close_pair();
      else if (b == CHAR_PLUS) add_event(EV_VALUE_BYTE, CHAR_SPACE);
      else if (b == CHAR_PERCENT) phase = PH_PCT1;
      else add_event(EV_VALUE_BYTE, b);
   endfunction

   function automatic void predict_item(input logic [7:0] b, input logic eob);
      item_events.delete();
      if (phase == PH_START) begin
         phase = (b == CHAR_LBRACE || b == CHAR_LANGLE) ? PH_SKIP : PH_NAME;
      end
      case (phase)
         PH_NAME: begin
            if (b == CHAR_EQUALS) begin
               add_event(EV_NAME_END, 8'h00);
               phase = PH_VALUE;
            end else begin
               add_event(EV_NAME_BYTE, b);
               name_started = 1'b1;
            end
         end
         PH_VALUE: value_phase_byte(b);
         PH_PCT1: begin
            if (is_hex(b)) begin
               held_digit = b;
               phase = PH_PCT2;
            end else begin
               add_event(EV_VALUE_BYTE, CHAR_PERCENT);
               phase = PH_VALUE;
               value_phase_byte(b);
            end
         end
         PH_PCT2: begin
            phase = PH_VALUE;
            if (is_hex(b)) begin
               add_event(EV_VALUE_BYTE, {nibble(held_digit), nibble(b)});
            end else begin
               add_event(EV_VALUE_BYTE, CHAR_PERCENT);
               add_event(EV_VALUE_BYTE, held_digit);
               value_phase_byte(b);
            end
            held_digit = 8'h00;
         end
         default: ;
      endcase
      // flush whatever is held at the end of the body
      if (eob) begin
         case (phase)
            PH_NAME: if (name_started) add_event(EV_ABANDONED, 8'h00);
            PH_VALUE: close_pair();
            PH_PCT1: begin
               add_event(EV_VALUE_BYTE, CHAR_PERCENT);
               close_pair();
            end
            PH_PCT2: begin
               add_event(EV_VALUE_BYTE, CHAR_PERCENT);
               add_event(EV_VALUE_BYTE, held_digit);
               close_pair();
            end
            default: ;
         endcase
         reset_parser();
      end
      if (item_events.size() > 0) item_events[item_events.size()-1].last_of_run = 1'b1;
      foreach (item_events[i]) expected_events.push_back(item_events[i]);
   endfunction

   always @(posedge clock) begin : monitor
      rsp_type exp_ev;
      string   diffs;
      if (reset) begin
         reset_parser();
         expected_events.delete();
         pending <= 0;
      end else begin
         // results first: an item never answers in its own cycle
         if (rsp_valid && !rsp_stall) begin
            events_seen++;
            if (expected_events.size() == 0) begin
               report_mismatch($sformatf("unexpected event %0d/%h/%0d/%b",
                  rsp_data.event_kind, rsp_data.data_byte, rsp_data.pair_number,
                  rsp_data.last_of_run));
            end else begin
               exp_ev = expected_events.pop_front();
               diffs = "";
               if (rsp_data.event_kind !== exp_ev.event_kind) diffs = {diffs, " event_kind"};
               if (rsp_data.data_byte !== exp_ev.data_byte) diffs = {diffs, " data_byte"};
               if (rsp_data.pair_number !== exp_ev.pair_number) diffs = {diffs, " pair_number"};
               if (rsp_data.last_of_run !== exp_ev.last_of_run) diffs = {diffs, " last_of_run"};
               if (diffs != "") begin
                  report_mismatch($sformatf("%s: got %0d/%h/%0d/%b, want %0d/%h/%0d/%b",
                     diffs, rsp_data.event_kind, rsp_data.data_byte, rsp_data.pair_number,
                     rsp_data.last_of_run, exp_ev.event_kind, exp_ev.data_byte,
                     exp_ev.pair_number, exp_ev.last_of_run));
               end
            end
         end
         if (req_valid && !req_stall) begin
            predict_item(req_data.body_byte, req_data.end_of_body);
         end
         pending <= expected_events.size();
      end
   end

endmodule

### tb/sv/tb_top.sv
// Top of the decoder testbench: clock, reset, body stimulus and the verdict.
// Instantiates form_urlencoded_decoder_unit and fud_checker; uses fud_pkg.
`timescale 1ns / 100ps

module tb_top;
   import fud_pkg::*;

   localparam int MAX_PAIRS = 64;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int fail_count;
   int pending;
   int events_seen;

   // idle odds, in percent of cycles, for each side
   int send_idle_pct = 0;
   int rcv_idle_pct  = 0;

   int items_sent  = 0;
   int bodies_sent = 0;

   // bytes of the body being built; the last one carries end_of_body
   logic [7:0] body_bytes[$];

   form_urlencoded_decoder_unit #(
      .MAX_PAIRS(MAX_PAIRS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   fud_checker #(
      .MAX_PAIRS(MAX_PAIRS)
   ) checker_inst (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .fail_count(fail_count),
      .pending(pending),
      .events_seen(events_seen)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Receiver back-pressure: a fresh coin each cycle, never during reset.
   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < rcv_idle_pct);
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("tb_top failed");
      $finish;
   end

   // One item: optional idle cycles first (decided without looking at
   // stall), then hold the byte until the decoder takes it.
   task automatic send_item(input logic [7:0] b, input logic eob);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= {b, eob};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_body();
      for (int i = 0; i < body_bytes.size(); i++) begin
         send_item(body_bytes[i], i == body_bytes.size() - 1);
      end
      body_bytes.delete();
      bodies_sent++;
   endtask

   // Sender goes quiet until every predicted event has come out. The wait before
   // polling pending lets the checker count the item taken at the last accept.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) body_bytes.push_back(s[i]);
   endtask

   function automatic logic [7:0] hex_char();
      string digits;
      digits = "0123456789abcdefABCDEF";
      return digits[$urandom_range(21)];
   endfunction

   // Anything but '=' so the name keeps going.
   function automatic logic [7:0] name_char();
      logic [7:0] c;
      c = 8'($urandom_range(255));
      return (c == CHAR_EQUALS) ? "n" : c;
   endfunction

   // Byte that breaks an escape; the specials test the replay path.
   function automatic logic [7:0] bad_char();
      case ($urandom_range(3))
         0: return 8'($urandom_range(8'h67, 8'h7A));   // g..z
         1: return CHAR_AMP;
         2: return CHAR_PLUS;
         default: return CHAR_PERCENT;
      endcase
   endfunction

   // One piece of a value: plain byte, '+', good escape or a broken one.
   task automatic add_value_token();
      logic [7:0] c;
      case ($urandom_range(5))
         0: body_bytes.push_back(CHAR_PLUS);
         1: begin
            body_bytes.push_back(CHAR_PERCENT);
            body_bytes.push_back(hex_char());
            body_bytes.push_back(hex_char());
         end
         2: begin
            body_bytes.push_back(CHAR_PERCENT);
            body_bytes.push_back(bad_char());
         end
         3: begin
            body_bytes.push_back(CHAR_PERCENT);
            body_bytes.push_back(hex_char());
            body_bytes.push_back(bad_char());
         end
         default: begin
            c = 8'($urandom_range(255));
            if (c == CHAR_AMP || c == CHAR_PERCENT) c = "v";
            body_bytes.push_back(c);
         end
      endcase
   endtask

   // Mostly well-formed bodies; some stub bodies and raw noise.
   task automatic build_random_body();
      int sel;
      int npairs;
      sel = $urandom_range(99);
      if (sel < 8) begin
         body_bytes.push_back($urandom_range(1) ? CHAR_LBRACE : CHAR_LANGLE);
         repeat ($urandom_range(4)) body_bytes.push_back(8'($urandom_range(255)));
      end else if (sel < 20) begin
         repeat ($urandom_range(1, 10)) body_bytes.push_back(8'($urandom_range(255)));
      end else begin
         npairs = $urandom_range(1, 4);
         for (int p = 0; p < npairs; p++) begin
            repeat ($urandom_range(3)) body_bytes.push_back(name_char());
            body_bytes.push_back(CHAR_EQUALS);
            repeat ($urandom_range(4)) add_value_token();
            if (p < npairs - 1) body_bytes.push_back(CHAR_AMP);
         end
         // how the body ends decides what the flush has to do
         case ($urandom_range(4))
            0: body_bytes.push_back(CHAR_AMP);
            1: begin
               body_bytes.push_back(CHAR_AMP);
               repeat ($urandom_range(1, 3)) body_bytes.push_back(name_char());
            end
            2: body_bytes.push_back(CHAR_PERCENT);
            3: begin
               body_bytes.push_back(CHAR_PERCENT);
               body_bytes.push_back(hex_char());
            end
            default: ;
         endcase
      end
   endtask

   // Enough tiny pairs to pass the pair limit; the tail must be skipped.
   task automatic build_flood_body();
      repeat (MAX_PAIRS + 2) begin
         body_bytes.push_back(CHAR_EQUALS);
         if ($urandom_range(3) == 0) add_value_token();
         body_bytes.push_back(CHAR_AMP);
      end
      repeat (3) body_bytes.push_back(8'($urandom_range(255)));
   endtask

   initial begin : stimulus
      int phase_end[3];
      phase_end[0] = 100;
      phase_end[1] = 170;
      phase_end[2] = 310;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed bodies, no idling ---
      // extreme name bytes, '+', good escape, broken escapes at first and
      // second digit, mixed-case escape, '&', then end right after "%F"
      body_bytes.push_back(8'h00);
      body_bytes.push_back(8'hFF);
      add_text("=+%41%z%ag%fF&%F");
      send_body();
      add_text("{=");                // stub body (JSON)
      send_body();
      add_text("<");                 // stub body (XML), one byte long
      send_body();
      add_text("x");                 // name never closed
      send_body();
      add_text("=%");                // end right after '%'
      send_body();
      add_text("=&");                // end after '&': nothing to flush
      send_body();
      add_text("%&");                // '%' and '&' are plain in a name
      send_body();
      drain_results();

      // --- random bodies in three idling regimes ---
      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin
               send_idle_pct = 10;
               rcv_idle_pct  = 86;
            end
            1: begin
               send_idle_pct = 86;
               rcv_idle_pct  = 10;
            end
            default: begin
               send_idle_pct = 0;
               rcv_idle_pct  = 0;
               build_flood_body();
               send_body();
            end
         endcase
         while (items_sent < phase_end[ph]) begin
            build_random_body();
            send_body();
         end
         drain_results();
      end

      // let any stray late events show up
      repeat (20) @(posedge clock);

      $display("Run covered %0d bytes in %0d bodies and checked %0d events,",
               items_sent, bodies_sent, events_seen);
      $display("including stub bodies, broken escapes, flushes and the pair limit.");
      if (fail_count == 0 && pending == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
